/* src/mxu_pkg.sv */
// Shared constants for the 4x4 fixed-point matrix add, subtract and multiply unit.
package mxu_pkg;

  parameter int DIM_DEF       = 4;
  parameter int FRAC_BITS_DEF = 16;

  parameter int DATA_W = 32;
  parameter int CMD_W  = 2;
  parameter int POS_W  = 4;

  parameter logic [CMD_W-1:0] CMD_ADD = 2'd0;
  parameter logic [CMD_W-1:0] CMD_SUB = 2'd1;
  parameter logic [CMD_W-1:0] CMD_MUL = 2'd2;

  parameter logic [DATA_W-1:0] SAT_MAX = {1'b0, {(DATA_W-1){1'b1}}};
  parameter logic [DATA_W-1:0] SAT_MIN = {1'b1, {(DATA_W-1){1'b0}}};

endpackage

/* src/matrix4x4_add_sub_mul.sv */
// Matrix unit top level: element load, shared multiply-accumulate datapath and result register.
//
//   channel | valid / stall             | payload
//   --------+---------------------------+-------------------------------------
//   in      | in_valid_i / in_stall_o   | cmd_i, left_elem_i, right_elem_i
//   out     | out_valid_o / out_stall_i | value_o, position_o, final_res_o
//
// In beats load while in_stall_o is low; the DIM*DIM-th beat starts a pass over the stores.
// Multiply passes issue DIM*DIM*DIM products (one 32x32 multiplier, one read port per
// store); add and subtract passes issue DIM*DIM element operations.
// in_stall_o is high for the whole pass. Reset clears the control state only.
// A stalled result register freezes the datapath when the next result is ready, until the beat is taken.
module matrix4x4_add_sub_mul #(
  parameter int DIM       = mxu_pkg::DIM_DEF,
  parameter int FRAC_BITS = mxu_pkg::FRAC_BITS_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic [mxu_pkg::CMD_W-1:0]       cmd_i,
  input  logic signed [mxu_pkg::DATA_W-1:0] left_elem_i,
  input  logic signed [mxu_pkg::DATA_W-1:0] right_elem_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic signed [mxu_pkg::DATA_W-1:0] value_o,
  output logic [mxu_pkg::POS_W-1:0]       position_o,
  output logic                            final_res_o
);

  localparam int DATA_W = mxu_pkg::DATA_W;
  localparam int POS_W  = mxu_pkg::POS_W;
  localparam int CELLS  = DIM * DIM;
  localparam int ADDR_W = $clog2(CELLS);
  localparam int K_W    = $clog2(DIM);
  localparam int PROD_W = 2 * DATA_W - FRAC_BITS;
  localparam int ACC_W  = PROD_W + $clog2(DIM);

  typedef enum logic [2:0] {
    ST_LOAD  = 3'b001,
    ST_ISSUE = 3'b010,
    ST_DRAIN = 3'b100
  } state_e;

  state_e state_q, state_d;

  logic                      in_acc;
  logic                      advance;
  logic                      issuing;
  logic                      last_issue;
  logic                      is_mul;
  logic [mxu_pkg::CMD_W-1:0] op_q;

  logic [ADDR_W-1:0] load_cnt_q;
  logic [ADDR_W-1:0] n_q;
  logic [K_W-1:0]    i_q, j_q, k_q;
  logic [ADDR_W-1:0] left_addr, right_addr;
  logic              iss_first, iss_last;

  logic signed [DATA_W-1:0] left_mem  [CELLS];
  logic signed [DATA_W-1:0] right_mem [CELLS];
  logic signed [DATA_W-1:0] left_rd_q, right_rd_q;

  logic              s1_vld_q, s1_first_q, s1_last_q;
  logic [ADDR_W-1:0] s1_n_q;
  logic              s2_vld_q, s2_first_q, s2_last_q;
  logic [ADDR_W-1:0] s2_n_q;

  logic signed [2*DATA_W-1:0] prod_full;
  logic signed [2*DATA_W-1:0] prod_shift;
  logic signed [DATA_W:0]     addsub;
  logic signed [PROD_W-1:0]   prod_d, prod_q;
  logic signed [ACC_W-1:0]    acc_q, acc_sum;
  logic                       pos_ovf, neg_ovf;
  logic [DATA_W-1:0]          sat_val;
  logic                       out_load;

  assign in_stall_o = (state_q != ST_LOAD);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign is_mul     = (op_q != mxu_pkg::CMD_ADD) && (op_q != mxu_pkg::CMD_SUB);
  assign advance    = !(s2_vld_q && s2_last_q && out_valid_o && out_stall_i);
  assign issuing    = (state_q == ST_ISSUE) && advance;

  assign iss_first  = is_mul ? (k_q == '0) : 1'b1;
  assign iss_last   = is_mul ? (k_q == K_W'(DIM - 1)) : 1'b1;
  assign last_issue = (n_q == ADDR_W'(CELLS - 1)) && iss_last;

  assign left_addr  = is_mul ? ADDR_W'(ADDR_W'(k_q) * ADDR_W'(DIM) + ADDR_W'(j_q)) : n_q;
  assign right_addr = is_mul ? ADDR_W'(ADDR_W'(i_q) * ADDR_W'(DIM) + ADDR_W'(k_q)) : n_q;

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_LOAD: begin
        if (in_acc && (load_cnt_q == ADDR_W'(CELLS - 1))) begin
          state_d = ST_ISSUE;
        end
      end
      ST_ISSUE: begin
        if (issuing && last_issue) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (!s1_vld_q && !s2_vld_q) begin
          state_d = ST_LOAD;
        end
      end
      default: state_d = ST_LOAD;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_LOAD;
      load_cnt_q <= '0;
      op_q       <= mxu_pkg::CMD_ADD;
    end else begin
      state_q <= state_d;
      if (in_acc) begin
        if (load_cnt_q == ADDR_W'(CELLS - 1)) begin
          load_cnt_q <= '0;
          op_q       <= cmd_i;
        end else begin
          load_cnt_q <= load_cnt_q + 1'b1;
        end
      end
    end
  end

  // Issue counters: walk result cells, and the inner index for products.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      n_q <= '0;
      i_q <= '0;
      j_q <= '0;
      k_q <= '0;
    end else if (issuing) begin
      if (last_issue) begin
        n_q <= '0;
        i_q <= '0;
        j_q <= '0;
        k_q <= '0;
      end else if (is_mul && !iss_last) begin
        k_q <= k_q + 1'b1;
      end else begin
        k_q <= '0;
        n_q <= n_q + 1'b1;
        if (j_q == K_W'(DIM - 1)) begin
          j_q <= '0;
          i_q <= i_q + 1'b1;
        end else begin
          j_q <= j_q + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      left_mem[load_cnt_q] <= left_elem_i;
    end
    if (advance) begin
      left_rd_q <= left_mem[left_addr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      right_mem[load_cnt_q] <= right_elem_i;
    end
    if (advance) begin
      right_rd_q <= right_mem[right_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
      s2_vld_q <= 1'b0;
    end else if (advance) begin
      s1_vld_q <= issuing;
      s2_vld_q <= s1_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      s1_first_q <= iss_first;
      s1_last_q  <= iss_last;
      s1_n_q     <= n_q;
      s2_first_q <= s1_first_q;
      s2_last_q  <= s1_last_q;
      s2_n_q     <= s1_n_q;
      prod_q     <= prod_d;
    end
  end

  // Shared unit: one multiply, or an add or subtract, per cycle unless a stalled result freezes the datapath.
  always_comb begin
    prod_full  = left_rd_q * right_rd_q;
    prod_shift = prod_full >>> FRAC_BITS;
    if (op_q == mxu_pkg::CMD_SUB) begin
      addsub = {left_rd_q[DATA_W-1], left_rd_q} - {right_rd_q[DATA_W-1], right_rd_q};
    end else begin
      addsub = {left_rd_q[DATA_W-1], left_rd_q} + {right_rd_q[DATA_W-1], right_rd_q};
    end
    if (is_mul) begin
      prod_d = prod_shift[PROD_W-1:0];
    end else begin
      prod_d = {{(PROD_W-DATA_W-1){addsub[DATA_W]}}, addsub};
    end
  end

  always_comb begin
    acc_sum = (s2_first_q ? '0 : acc_q) + {{(ACC_W-PROD_W){prod_q[PROD_W-1]}}, prod_q};
    pos_ovf = !acc_sum[ACC_W-1] && (|acc_sum[ACC_W-2:DATA_W-1]);
    neg_ovf = acc_sum[ACC_W-1] && !(&acc_sum[ACC_W-2:DATA_W-1]);
    if (pos_ovf) begin
      sat_val = mxu_pkg::SAT_MAX;
    end else if (neg_ovf) begin
      sat_val = mxu_pkg::SAT_MIN;
    end else begin
      sat_val = acc_sum[DATA_W-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && s2_vld_q) begin
      acc_q <= acc_sum;
    end
  end

  assign out_load = advance && s2_vld_q && s2_last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_o <= 1'b0;
    end else if (out_load) begin
      out_valid_o <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_o <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      value_o     <= sat_val;
      position_o  <= POS_W'(s2_n_q);
      final_res_o <= (s2_n_q == ADDR_W'(CELLS - 1));
    end
  end

  a_load_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |-> (!s1_vld_q && !s2_vld_q))
    else $error("input beat accepted while datapath busy");

  a_hold_on_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s2_vld_q && s2_last_q && out_valid_o && out_stall_i) |=>
      ($stable(prod_q) && $stable(s2_n_q) && $stable(value_o)))
    else $error("datapath advanced under a stalled result");

  a_final_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && final_res_o) |-> (position_o == POS_W'(CELLS - 1)))
    else $error("last result at wrong position");

endmodule
